// File: rtl/xypr_pkg.sv
// Package for the XY path record and playback block.
// Holds command codes, register indexes, reset values and the shared types.
// No dependencies.
package xypr_pkg;

    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_START_REC = 3'd1;
    localparam logic [2:0] CMD_STOP_REC  = 3'd2;
    localparam logic [2:0] CMD_PLAY      = 3'd3;
    localparam logic [2:0] CMD_STOP_PLAY = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 3'd3;

    localparam logic [15:0] SPEED_RESET  = 16'd4096;
    localparam logic [15:0] SPEED_MIN    = 16'd41;
    localparam logic [15:0] THRESH_RESET = 16'd131;
    localparam logic [31:0] GAP_RESET    = 32'd16384;

    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = 6;

    typedef struct packed {
        logic [31:0] b;
        logic [15:0] y;
        logic [15:0] x;
    } t_point;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_APPLY,
        OP_RD_LAST,
        OP_APPEND,
        OP_LATCH_DUR,
        OP_MUL_T,
        OP_STOP_PLAY,
        OP_MOD_START,
        OP_MOD_TAKE,
        OP_SCAN_FIRST,
        OP_SCAN_PREV,
        OP_SCAN_STEP,
        OP_LERP_MUL,
        OP_LERP_DIV,
        OP_LERP_TAKE,
        OP_OUT_LOAD
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_APPEND,
        ST_RLAST,
        ST_RCHK,
        ST_DUR,
        ST_MUL,
        ST_CMP,
        ST_MOD,
        ST_SCAN0,
        ST_SCAN1,
        ST_SCAN,
        ST_LMUL,
        ST_LDIV,
        ST_LWAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       new_frame;
        logic       recording;
        logic       playing;
        logic       len_zero;
        logic       len_ge2;
        logic       take;
        logic       dur_zero;
        logic       t_gt_dur;
        logic       loop_en;
        logic       found;
        logic       scan_last;
        logic       div_done;
        logic       axis_y;
        logic       out_free;
    } t_stat;

endpackage

// File: rtl/xypr_if.sv
// Handshake channel interfaces: input item, result item, configuration write.
// Depends on xypr_pkg.
interface xypr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [31:0] beat_time;
    logic [15:0] pad_x;
    logic [15:0] pad_y;
    logic [31:0] frame_id;
    modport source (output valid, cmd, beat_time, pad_x, pad_y, frame_id, input ready);
    modport sink (input valid, cmd, beat_time, pad_x, pad_y, frame_id, output ready);
endinterface

interface xypr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic        is_recording;
    logic        is_playing;
    logic [8:0]  point_count;
    logic        store_full;
    modport source (output valid, out_x, out_y, is_recording, is_playing, point_count,
                    store_full, input ready);
    modport sink (input valid, out_x, out_y, is_recording, is_playing, point_count,
                  store_full, output ready);
endinterface

interface xypr_cfg_if;
    import xypr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/xy_path_record_playback_top.sv
// Top level of the XY path record and playback block: controller plus datapath.
// Depends on xypr_pkg, xypr_if, xypr_ctrl and xypr_dp.
//
//  channel  dir  handshake            payload
//  i_in     in   valid/ready          cmd, beat_time, pad_x, pad_y, frame_id
//  o_out    out  valid/ready          out_x, out_y, is_recording, is_playing,
//                                     point_count, store_full
//  i_cfg    in   valid/ready (ready 1) index, data
//
// Non-tick commands and repeated frames go straight to the result; a recording tick first
// reads the last point (not when the path is empty). A playback tick reads the last point,
// scales the time, wraps it on the serial divider when looping, reads one point per scan step
// and runs one division per axis; it ends early for a zero duration or when it stops at the end.
// Reset is synchronous; the path RAM is not cleared, only entries below the length are read.
// A finished result waits in the output register; the next transfer is taken meanwhile.
module xy_path_record_playback_top #(
    parameter int PATH_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xypr_in_if.sink     i_in,
    xypr_out_if.source  o_out,
    xypr_cfg_if.sink    i_cfg
);
    import xypr_pkg::*;

    localparam logic [8:0] DEPTH_LOW = 9'(PATH_DEPTH);

    t_ctl  w_ctl;
    t_stat w_stat;

    xypr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    xypr_dp #(.PATH_DEPTH(PATH_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .o_stat         (w_stat),
        .i_cmd          (i_in.cmd),
        .i_beat_time    (i_in.beat_time),
        .i_pad_x        (i_in.pad_x),
        .i_pad_y        (i_in.pad_y),
        .i_frame_id     (i_in.frame_id),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_out_x        (o_out.out_x),
        .o_out_y        (o_out.out_y),
        .o_is_recording (o_out.is_recording),
        .o_is_playing   (o_out.is_playing),
        .o_point_count  (o_out.point_count),
        .o_store_full   (o_out.store_full)
    );

    assign i_in.ready  = w_ctl.in_ready;
    assign i_cfg.ready = 1'b1;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in work");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.is_recording && o_out.is_playing))
        else $error("recording and playing together");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.store_full) |-> (o_out.point_count == DEPTH_LOW))
        else $error("drop flagged below full store");

    a_full_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.store_full) |-> o_out.is_recording)
        else $error("drop flagged while not recording");
endmodule

// File: rtl/xypr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xypr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: rtl/xypr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on xypr_pkg.
module xypr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [xypr_pkg::DIV_NW-1:0] i_num,
    input  logic [xypr_pkg::DIV_DW-1:0] i_den,
    output logic [xypr_pkg::DIV_NW-1:0] o_quot,
    output logic [xypr_pkg::DIV_DW-1:0] o_rem,
    output logic                      o_done
);
    import xypr_pkg::*;

    logic [DIV_NW-1:0] r_q, n_q;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_DW:0]   w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_q[DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_start) begin
            n_q    = i_num;
            n_rem  = '0;
            n_cnt  = DIV_CW'(DIV_NW - 1);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            n_q   = {r_q[DIV_NW-2:0], w_ge};
            n_rem = w_ge ? DIV_DW'(w_trial - {1'b0, r_den}) : w_trial[DIV_DW-1:0];
            n_cnt = r_cnt - DIV_CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_quot = r_q;
    assign o_rem  = r_rem;
    assign o_done = r_done;
endmodule

// File: rtl/xypr_ctrl.sv
// Controller state machine: sequences decode, recording, playback and result load.
// Depends on xypr_pkg.
module xypr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  xypr_pkg::t_stat i_stat,
    output xypr_pkg::t_ctl  o_ctl
);
    import xypr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ctl.op       = OP_NONE;
        o_ctl.in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.op = OP_CAPTURE;
                    n_state  = ST_APPLY;
                end
            end
            ST_APPLY: begin
                o_ctl.op = OP_APPLY;
                n_state  = ST_DONE;
                if (i_stat.cmd == CMD_TICK && i_stat.new_frame) begin
                    if (i_stat.recording) begin
                        n_state = i_stat.len_zero ? ST_APPEND : ST_RLAST;
                    end else if (i_stat.playing && i_stat.len_ge2) begin
                        n_state = ST_RLAST;
                    end
                end
            end
            ST_APPEND: begin
                o_ctl.op = OP_APPEND;
                n_state  = ST_DONE;
            end
            ST_RLAST: begin
                o_ctl.op = OP_RD_LAST;
                n_state  = i_stat.recording ? ST_RCHK : ST_DUR;
            end
            ST_RCHK: begin
                if (i_stat.take) begin
                    o_ctl.op = OP_APPEND;
                end
                n_state = ST_DONE;
            end
            ST_DUR: begin
                o_ctl.op = OP_LATCH_DUR;
                n_state  = i_stat.dur_zero ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                o_ctl.op = OP_MUL_T;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                if (!i_stat.t_gt_dur) begin
                    n_state = ST_SCAN0;
                end else if (!i_stat.loop_en) begin
                    o_ctl.op = OP_STOP_PLAY;
                    n_state  = ST_DONE;
                end else begin
                    o_ctl.op = OP_MOD_START;
                    n_state  = ST_MOD;
                end
            end
            ST_MOD: begin
                if (i_stat.div_done) begin
                    o_ctl.op = OP_MOD_TAKE;
                    n_state  = ST_SCAN0;
                end
            end
            ST_SCAN0: begin
                o_ctl.op = OP_SCAN_FIRST;
                n_state  = ST_SCAN1;
            end
            ST_SCAN1: begin
                o_ctl.op = OP_SCAN_PREV;
                n_state  = ST_SCAN;
            end
            ST_SCAN: begin
                o_ctl.op = OP_SCAN_STEP;
                if (i_stat.found) begin
                    n_state = ST_LMUL;
                end else if (i_stat.scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_LMUL: begin
                o_ctl.op = OP_LERP_MUL;
                n_state  = ST_LDIV;
            end
            ST_LDIV: begin
                o_ctl.op = OP_LERP_DIV;
                n_state  = ST_LWAIT;
            end
            ST_LWAIT: begin
                if (i_stat.div_done) begin
                    o_ctl.op = OP_LERP_TAKE;
                    n_state  = i_stat.axis_y ? ST_DONE : ST_LMUL;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.op = OP_OUT_LOAD;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

// File: rtl/xypr_dp.sv
// Datapath: state registers, path RAM, playback time, scan, interpolation, result register.
// Depends on xypr_pkg, xypr_ram and xypr_div.
module xypr_dp #(
    parameter int PATH_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  xypr_pkg::t_ctl                i_ctl,
    output xypr_pkg::t_stat               o_stat,
    input  logic [2:0]                    i_cmd,
    input  logic [31:0]                   i_beat_time,
    input  logic [15:0]                   i_pad_x,
    input  logic [15:0]                   i_pad_y,
    input  logic [31:0]                   i_frame_id,
    input  logic                          i_cfg_valid,
    input  logic [xypr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [15:0]                   o_out_x,
    output logic [15:0]                   o_out_y,
    output logic                          o_is_recording,
    output logic                          o_is_playing,
    output logic [8:0]                    o_point_count,
    output logic                          o_store_full
);
    import xypr_pkg::*;

    localparam int ADDR_W = $clog2(PATH_DEPTH);
    localparam int LEN_W  = $clog2(PATH_DEPTH + 1);

    logic [15:0] r_speed, r_thresh;
    logic        r_loop;
    logic [31:0] r_gap;

    logic [2:0]  r_cmd;
    logic [31:0] r_beat, r_frame;
    logic [LEN_W-1:0] r_len, r_idx;
    logic [31:0] r_start, r_last_frame;
    logic        r_rec, r_play, r_fv, r_drop, r_axis;
    logic [15:0] r_pad_x, r_pad_y, r_nx;
    logic [31:0] r_dur;
    logic [35:0] r_t;
    t_point      r_prev, r_cur;
    logic signed [50:0] r_prod;
    logic [31:0] r_span;

    logic        r_ovalid;
    logic [15:0] r_ox, r_oy;
    logic        r_orec, r_oplay, r_ofull;
    logic [8:0]  r_ocnt;

    t_point      w_rd;
    logic [63:0] w_rd_raw;
    logic        w_rd_en, w_wr_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [LEN_W-1:0]  w_len_m1, w_idx_p1;
    logic [31:0] w_off, w_elapsed, w_len_ext;
    logic [15:0] w_dx, w_dy, w_sp;
    logic [47:0] w_tprod;
    logic        w_div_start, w_div_done;
    logic [DIV_NW-1:0] w_div_num, w_quot;
    logic [DIV_DW-1:0] w_div_den, w_rem;
    logic [15:0] w_a, w_b;
    logic signed [16:0] w_diff;
    logic signed [33:0] w_num;
    logic signed [50:0] w_prod;
    logic signed [32:0] w_span;
    logic [50:0] w_mag;
    logic [49:0] w_qs, w_v;
    logic [15:0] w_sat;
    logic        w_new_frame;

    assign w_len_m1  = r_len - LEN_W'(1);
    assign w_idx_p1  = r_idx + LEN_W'(1);
    assign w_off     = r_beat - r_start;
    assign w_elapsed = w_off;
    assign w_rd      = t_point'(w_rd_raw);
    assign w_new_frame = !r_fv || (r_frame != r_last_frame);

    always_comb begin
        w_rd_en   = 1'b1;
        w_rd_addr = w_len_m1[ADDR_W-1:0];
        case (i_ctl.op)
            OP_RD_LAST:    w_rd_addr = w_len_m1[ADDR_W-1:0];
            OP_SCAN_FIRST: w_rd_addr = '0;
            OP_SCAN_PREV:  w_rd_addr = r_idx[ADDR_W-1:0];
            OP_SCAN_STEP:  w_rd_addr = w_idx_p1[ADDR_W-1:0];
            default:       w_rd_en   = 1'b0;
        endcase
    end

    assign w_wr_en = (i_ctl.op == OP_APPEND) && (r_len != LEN_W'(PATH_DEPTH));

    xypr_ram #(.WIDTH(64), .DEPTH(PATH_DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_len[ADDR_W-1:0]),
        .i_wr_data ({w_off, r_pad_y, r_pad_x}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    assign w_dx = (w_rd.x > r_pad_x) ? w_rd.x - r_pad_x : r_pad_x - w_rd.x;
    assign w_dy = (w_rd.y > r_pad_y) ? w_rd.y - r_pad_y : r_pad_y - w_rd.y;

    assign w_sp    = (r_speed < SPEED_MIN) ? SPEED_MIN : r_speed;
    assign w_tprod = w_elapsed * w_sp;

    assign w_a    = r_axis ? r_prev.y : r_prev.x;
    assign w_b    = r_axis ? r_cur.y : r_cur.x;
    assign w_diff = $signed({1'b0, w_b}) - $signed({1'b0, w_a});
    assign w_num  = $signed({2'b0, r_t[31:0]}) - $signed({2'b0, r_prev.b});
    assign w_prod = w_diff * w_num;
    assign w_span = $signed({1'b0, r_cur.b}) - $signed({1'b0, r_prev.b});
    assign w_mag  = r_prod[50] ? 51'(-r_prod) : 51'(r_prod);
    assign w_qs   = {2'b0, w_quot};
    assign w_v    = {34'b0, w_a} + (r_prod[50] ? -w_qs : w_qs);
    assign w_sat  = w_v[49] ? 16'd0 : ((w_v[48:16] != '0) ? 16'hFFFF : w_v[15:0]);

    assign w_div_start = (i_ctl.op == OP_MOD_START) || (i_ctl.op == OP_LERP_DIV);
    assign w_div_num   = (i_ctl.op == OP_MOD_START) ? DIV_NW'(r_t) : w_mag[DIV_NW-1:0];
    assign w_div_den   = (i_ctl.op == OP_MOD_START) ? r_dur : r_span;

    xypr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quot  (w_quot),
        .o_rem   (w_rem),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed      <= SPEED_RESET;
            r_loop       <= 1'b0;
            r_thresh     <= THRESH_RESET;
            r_gap        <= GAP_RESET;
            r_len        <= '0;
            r_start      <= '0;
            r_rec        <= 1'b0;
            r_play       <= 1'b0;
            r_last_frame <= '0;
            r_fv         <= 1'b0;
            r_pad_x      <= '0;
            r_pad_y      <= '0;
            r_ovalid     <= 1'b0;
            r_axis       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SPEED:  r_speed  <= i_cfg_data[15:0];
                    CFG_LOOP:   r_loop   <= i_cfg_data[0];
                    CFG_THRESH: r_thresh <= i_cfg_data[15:0];
                    CFG_GAP:    r_gap    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctl.op == OP_OUT_LOAD) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_ctl.op)
                OP_CAPTURE: begin
                    if (!r_play) begin
                        r_pad_x <= i_pad_x;
                        r_pad_y <= i_pad_y;
                    end
                    r_axis <= 1'b0;
                end
                OP_APPLY: begin
                    case (r_cmd)
                        CMD_TICK: begin
                            if (w_new_frame) begin
                                r_last_frame <= r_frame;
                                r_fv         <= 1'b1;
                            end
                        end
                        CMD_START_REC: begin
                            r_len   <= '0;
                            r_rec   <= 1'b1;
                            r_play  <= 1'b0;
                            r_start <= r_beat;
                        end
                        CMD_STOP_REC: r_rec <= 1'b0;
                        CMD_PLAY: begin
                            if (r_len >= LEN_W'(2)) begin
                                r_play  <= 1'b1;
                                r_rec   <= 1'b0;
                                r_start <= r_beat;
                            end
                        end
                        CMD_STOP_PLAY: r_play <= 1'b0;
                        CMD_CLEAR: begin
                            r_len  <= '0;
                            r_play <= 1'b0;
                            r_rec  <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                OP_APPEND: begin
                    if (w_wr_en) begin
                        r_len <= r_len + LEN_W'(1);
                    end
                end
                OP_STOP_PLAY: r_play <= 1'b0;
                OP_LERP_TAKE: begin
                    r_axis <= 1'b1;
                    if (r_axis) begin
                        r_pad_x <= r_nx;
                        r_pad_y <= w_sat;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_CAPTURE: begin
                r_cmd   <= i_cmd;
                r_beat  <= i_beat_time;
                r_frame <= i_frame_id;
                r_drop  <= 1'b0;
            end
            OP_APPEND:     r_drop <= !w_wr_en;
            OP_LATCH_DUR:  r_dur  <= w_rd.b;
            OP_MUL_T:      r_t    <= w_tprod[47:12];
            OP_MOD_TAKE:   r_t    <= {4'b0, w_rem};
            OP_SCAN_FIRST: r_idx  <= LEN_W'(1);
            OP_SCAN_PREV:  r_prev <= w_rd;
            OP_SCAN_STEP: begin
                if ({4'b0, w_rd.b} >= r_t) begin
                    r_cur <= w_rd;
                end else begin
                    r_prev <= w_rd;
                    r_idx  <= w_idx_p1;
                end
            end
            OP_LERP_MUL: begin
                r_prod <= w_prod;
                r_span <= (w_span < 33'sd1) ? 32'd1 : w_span[31:0];
            end
            OP_LERP_TAKE: r_nx <= w_sat;
            OP_OUT_LOAD: begin
                r_ox    <= r_pad_x;
                r_oy    <= r_pad_y;
                r_orec  <= r_rec;
                r_oplay <= r_play;
                r_ocnt  <= w_len_ext[8:0];
                r_ofull <= r_drop;
            end
            default: ;
        endcase
    end

    assign w_len_ext = 32'(r_len);

    assign o_stat.cmd       = r_cmd;
    assign o_stat.new_frame = w_new_frame;
    assign o_stat.recording = r_rec;
    assign o_stat.playing   = r_play;
    assign o_stat.len_zero  = (r_len == '0);
    assign o_stat.len_ge2   = (r_len >= LEN_W'(2));
    assign o_stat.take      = (w_dx > r_thresh) || (w_dy > r_thresh) || ((w_off - w_rd.b) > r_gap);
    assign o_stat.dur_zero  = (w_rd.b == '0);
    assign o_stat.t_gt_dur  = r_t > {4'b0, r_dur};
    assign o_stat.loop_en   = r_loop;
    assign o_stat.found     = {4'b0, w_rd.b} >= r_t;
    assign o_stat.scan_last = (r_idx == w_len_m1);
    assign o_stat.div_done  = w_div_done;
    assign o_stat.axis_y    = r_axis;
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid    = r_ovalid;
    assign o_out_x        = r_ox;
    assign o_out_y        = r_oy;
    assign o_is_recording = r_orec;
    assign o_is_playing   = r_oplay;
    assign o_point_count  = r_ocnt;
    assign o_store_full   = r_ofull;
endmodule
